// ===== rtl/core/sma_pkg.sv =====
package sma_pkg;

  // Fixed field widths
  localparam int AVG_W  = 32;  // result width
  localparam int WL_W   = 9;   // window_length register width
  localparam int DATA_W = 32;  // APB data width
  localparam int ADDR_W = 3;   // APB address width

  // Register map (word index)
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  localparam logic [WL_W-1:0] WL_RESET = WL_W'(1);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_FINISH
  } sma_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // latch sample, read oldest ring entry
    logic update;     // write ring, update sum and count
    logic div_start;  // load divider with new sum
    logic out_load;   // move quotient to output register
  } sma_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic produce;    // window full after this sample
    logic div_busy;
    logic out_free;   // output register empty or being drained
  } sma_sts_t;

endpackage

// ===== rtl/core/simple_moving_average_unit.sv =====
// Flow: a sample is captured in ST_IDLE, the sum and fill count are updated in ST_UPDATE,
// the bit-serial divider on SUM_W = SAMPLE_WIDTH + log2(MAX_WINDOW) bits (40 at defaults) runs
// in ST_DIVIDE when the window is full, and the quotient is loaded in ST_FINISH. A new item
// is taken only in ST_IDLE; a result held by out_ready stalls the next item further.
// Reset (synchronous, rst high) clears sum, fill count and write slot, sets
// window_length to 1; ring contents are not cleared.
module simple_moving_average_unit #(
  parameter int MAX_WINDOW   = 256,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sma_pkg::ADDR_W-1:0] paddr,
  input  logic [sma_pkg::DATA_W-1:0] pwdata,
  output logic [sma_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic [SAMPLE_WIDTH-1:0]    price_sample,
  input  logic                       end_of_series,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic [sma_pkg::AVG_W-1:0]  average,
  output logic                       out_valid,
  input  logic                       out_ready
);

  import sma_pkg::*;

  sma_cmd_t        cmd;
  sma_sts_t        sts;
  logic            cfg_we;
  logic [WL_W-1:0] window_length;

  // APB decode: one register, word addressed
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1] == REG_WINDOW_LENGTH);

  always_comb begin
    if (paddr[ADDR_W-1] == REG_WINDOW_LENGTH) begin
      prdata = DATA_W'(window_length);
    end else begin
      prdata = '0;
    end
  end

  sma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sma_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (pwdata[WL_W-1:0]),
    .window_length(window_length),
    .price_sample (price_sample),
    .end_of_series(end_of_series),
    .average      (average),
    .out_valid    (out_valid),
    .out_ready    (out_ready)
  );

endmodule

// ===== rtl/core/sma_ram.sv =====
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sma_div.sv =====
module sma_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem, quotient[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(DVD_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DVS_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DVS_W-1:0];
      end
      quotient <= {quotient[DVD_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/core/sma_ctrl.sv =====
module sma_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sma_pkg::sma_sts_t sts,
  output sma_pkg::sma_cmd_t cmd
);

  import sma_pkg::*;

  sma_state_t state;
  sma_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.produce) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIVIDE;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (!sts.div_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/sma_dp.sv =====
module sma_dp #(
  parameter int MAX_WINDOW   = 256,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  sma_pkg::sma_cmd_t         cmd,
  output sma_pkg::sma_sts_t         sts,
  input  logic                      cfg_we,
  input  logic [sma_pkg::WL_W-1:0]  cfg_wdata,
  output logic [sma_pkg::WL_W-1:0]  window_length,
  input  logic [SAMPLE_WIDTH-1:0]   price_sample,
  input  logic                      end_of_series,
  output logic [sma_pkg::AVG_W-1:0] average,
  output logic                      out_valid,
  input  logic                      out_ready
);

  import sma_pkg::*;

  localparam int IDX_W = $clog2(MAX_WINDOW);
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_WIDTH + $clog2(MAX_WINDOW);
  localparam logic [LEN_W:0] MAX_L = (LEN_W + 1)'(MAX_WINDOW);

  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    last;
  logic [IDX_W-1:0]        write_slot;
  logic [LEN_W-1:0]        fill_count;
  logic [SUM_W-1:0]        running_sum;

  logic [LEN_W-1:0]        eff_len;
  logic                    full;
  logic [LEN_W:0]          slot_ext;
  logic [LEN_W:0]          oldest_ext;
  logic [IDX_W-1:0]        oldest;
  logic [SAMPLE_WIDTH-1:0] old_sample;
  logic [SUM_W-1:0]        old_term;
  logic [SUM_W-1:0]        new_sum;
  logic [LEN_W-1:0]        fill_new;
  logic                    div_busy;
  logic [SUM_W-1:0]        quotient;
  logic [SUM_W+AVG_W-1:0]  quo_ext;

  // Length in use: zero acts as one, saturate at ring depth
  always_comb begin
    if (window_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_length);
    end
  end

  assign full = fill_count >= eff_len;

  // Oldest entry in window, modulo ring depth
  assign slot_ext = (LEN_W + 1)'(write_slot);
  always_comb begin
    if (slot_ext >= {1'b0, eff_len}) begin
      oldest_ext = slot_ext - {1'b0, eff_len};
    end else begin
      oldest_ext = slot_ext + MAX_L - {1'b0, eff_len};
    end
  end
  assign oldest = oldest_ext[IDX_W-1:0];

  sma_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(write_slot),
    .wdata(sample),
    .re   (cmd.accept),
    .raddr(oldest),
    .rdata(old_sample)
  );

  // Sum and count after this sample
  assign old_term = full ? SUM_W'(old_sample) : '0;
  assign new_sum  = running_sum - old_term + SUM_W'(sample);
  assign fill_new = full ? fill_count : fill_count + LEN_W'(1);

  assign sts.produce  = fill_new >= eff_len;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid || out_ready;

  // Input transaction capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample <= price_sample;
      last   <= end_of_series;
    end
  end

  // History state and window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
      write_slot    <= '0;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cfg_we) begin
      window_length <= cfg_wdata;
      fill_count    <= '0;
      running_sum   <= '0;
    end else if (cmd.update) begin
      if (write_slot == IDX_W'(MAX_WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + IDX_W'(1);
      end
      if (last) begin
        fill_count  <= '0;
        running_sum <= '0;
      end else begin
        fill_count  <= fill_new;
        running_sum <= new_sum;
      end
    end
  end

  sma_div #(
    .DVD_W(SUM_W),
    .DVS_W(LEN_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(new_sum),
    .divisor (eff_len),
    .busy    (div_busy),
    .quotient(quotient)
  );

  // Output register
  assign quo_ext = {AVG_W'(0), quotient};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average <= quo_ext[AVG_W-1:0];
    end
  end

endmodule
